FILE: sv/bfgr_pkg.sv
`default_nettype none
package bfgr_pkg;

   // Sizes of the font stores
   localparam int MAX_GLYPH_WIDTH  = 16;
   localparam int MAX_GLYPH_HEIGHT = 16;
   localparam int ATLAS_ADDR_W     = 16;
   localparam int ATLAS_PIXELS     = 1 << ATLAS_ADDR_W;
   localparam int CELL_LIMIT       = (MAX_GLYPH_HEIGHT < 16) ? MAX_GLYPH_HEIGHT : 16;
   localparam int CMDQ_DEPTH       = 4;
   localparam int CMDQ_AW          = 2;

   // Operation codes
   localparam logic [1:0] OP_LOAD_WIDTH = 2'd0;
   localparam logic [1:0] OP_LOAD_ATLAS = 2'd1;
   localparam logic [1:0] OP_SET_POS    = 2'd2;
   localparam logic [1:0] OP_DRAW       = 2'd3;

   // Control characters and constants
   localparam logic [7:0]  CODE_TAB     = 8'd9;
   localparam logic [7:0]  CODE_NEWLINE = 8'd10;
   localparam logic [15:0] INK_VALUE    = 16'hFFFF;
   localparam logic [15:0] TAB_STEP     = 16'd32;

   // Register indexes
   localparam logic [2:0] CSR_FIRST_CHAR  = 3'd0;
   localparam logic [2:0] CSR_CELL_WIDTH  = 3'd1;
   localparam logic [2:0] CSR_CELL_HEIGHT = 3'd2;
   localparam logic [2:0] CSR_ATLAS_WIDTH = 3'd3;
   localparam logic [2:0] CSR_TEXT_COLOR  = 3'd4;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  char_code;
      logic [7:0]  glyph_width_value;
      logic [15:0] atlas_address;
      logic [15:0] atlas_pixel;
      logic [15:0] position_x;
      logic [15:0] position_y;
   } req_type;

   typedef struct packed {
      logic [15:0] dest_x;
      logic [15:0] dest_y;
      logic [15:0] column_mask;
      logic [15:0] pixel_color;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  first_char;
      logic [4:0]  cell_width;
      logic [4:0]  cell_height;
      logic [8:0]  atlas_width;
      logic [15:0] text_color;
   } cfg_type;

   // Work handed from front to back: an atlas write or one glyph
   typedef struct packed {
      logic                    is_glyph;
      logic [ATLAS_ADDR_W-1:0] addr;
      logic                    ink;
      logic [15:0]             x;
      logic [15:0]             y;
      logic [4:0]              width;
      logic                    blank;
   } cmd_type;

   function automatic logic [4:0] eff_cell_width(input logic [4:0] v);
      if (v == 5'd0) return 5'd1;
      if (v > 5'd16) return 5'd16;
      return v;
   endfunction

   function automatic logic [4:0] eff_cell_height(input logic [4:0] v);
      if (v == 5'd0) return 5'd1;
      if (v > 5'(CELL_LIMIT)) return 5'(CELL_LIMIT);
      return v;
   endfunction

   function automatic logic [8:0] eff_atlas_width(input logic [8:0] v);
      if (v == 9'd0) return 9'd1;
      if (v > 9'd256) return 9'd256;
      return v;
   endfunction

endpackage
`default_nettype wire

FILE: sv/bfgr_div.sv
`default_nettype none
module bfgr_div (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic [8:0] dividend,
   input  wire logic [8:0] divisor,
   output logic            done,
   output logic [8:0]      quot,
   output logic [8:0]      rem
);

   logic       busy_ff;
   logic       done_ff;
   logic [3:0] cnt_ff;
   logic [8:0] quot_ff;
   logic [8:0] rem_ff;
   logic [8:0] dsr_ff;
   logic [9:0] rem_sh;
   logic       fits;
   logic [8:0] rem_in;

   // One quotient bit per step
   always_comb begin
      rem_sh = {rem_ff, quot_ff[8]};
      fits   = rem_sh >= {1'b0, dsr_ff};
      rem_in = fits ? 9'(rem_sh - {1'b0, dsr_ff}) : rem_sh[8:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 4'd0;
            quot_ff <= dividend;
            rem_ff  <= 9'd0;
            dsr_ff  <= divisor;
         end else if (busy_ff) begin
            quot_ff <= {quot_ff[7:0], fits};
            rem_ff  <= rem_in;
            cnt_ff  <= cnt_ff + 4'd1;
            if (cnt_ff == 4'd8) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule
`default_nettype wire

FILE: sv/bfgr_front.sv
`default_nettype none
module bfgr_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire bfgr_pkg::req_type req_data,
   input  wire bfgr_pkg::cfg_type cfg,
   output logic                  q_push,
   output bfgr_pkg::cmd_type     q_data,
   input  wire logic             q_full
);

   typedef enum logic [2:0] {
      S_IDLE, S_WREAD, S_DIV_COLS, S_DIV_POS, S_MUL_A, S_MUL_B, S_PUSH
   } state_type;

   state_type         state_ff;
   bfgr_pkg::cmd_type cmd_ff;
   logic [15:0]       cur_x_ff;
   logic [15:0]       cur_y_ff;
   logic [15:0]       line_x_ff;
   logic [7:0]        pos_ff;
   logic [15:0]       bx_ff;
   logic [15:0]       by_ff;
   logic [4:0]        wmem [256];
   logic [4:0]        wdata_ff;

   logic        accept;
   logic [4:0]  cw;
   logic [4:0]  ch;
   logic [8:0]  aw;
   logic [4:0]  wsat;
   logic [15:0] tab_sum;
   logic        blank;
   logic        div_start;
   logic        div_done;
   logic [8:0]  div_quot;
   logic [8:0]  div_rem;
   logic [8:0]  cols;
   logic [8:0]  dividend;
   logic [8:0]  divisor;

   always_comb begin
      accept    = req_push && (state_ff == S_IDLE);
      cw        = bfgr_pkg::eff_cell_width(cfg.cell_width);
      ch        = bfgr_pkg::eff_cell_height(cfg.cell_height);
      aw        = bfgr_pkg::eff_atlas_width(cfg.atlas_width);
      wsat      = (req_data.glyph_width_value > 8'(bfgr_pkg::MAX_GLYPH_WIDTH)) ?
                  5'(bfgr_pkg::MAX_GLYPH_WIDTH) : req_data.glyph_width_value[4:0];
      tab_sum   = cur_x_ff + bfgr_pkg::TAB_STEP;
      blank     = cmd_ff.blank;
      cols      = (div_quot == 9'd0) ? 9'd1 : div_quot;
      div_start = ((state_ff == S_WREAD) && (wdata_ff != 5'd0) && !blank) ||
                  ((state_ff == S_DIV_COLS) && div_done);
      dividend  = (state_ff == S_WREAD) ? aw : {1'b0, pos_ff};
      divisor   = (state_ff == S_WREAD) ? {4'd0, cw} : cols;
   end

   bfgr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   // Width table: write on load, registered read
   always_ff @(posedge clock) begin
      if (accept && (req_data.operation == bfgr_pkg::OP_LOAD_WIDTH)) begin
         wmem[req_data.char_code] <= wsat;
      end
      wdata_ff <= wmem[req_data.char_code];
   end

   // Classify transactions, track cursor, build commands
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cur_x_ff  <= 16'd0;
         cur_y_ff  <= 16'd0;
         line_x_ff <= 16'd0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  cmd_ff.x     <= cur_x_ff;
                  cmd_ff.y     <= cur_y_ff;
                  cmd_ff.addr  <= req_data.atlas_address;
                  cmd_ff.ink   <= (req_data.atlas_pixel == bfgr_pkg::INK_VALUE);
                  cmd_ff.blank <= (req_data.char_code < cfg.first_char);
                  pos_ff       <= 8'(req_data.char_code - cfg.first_char);
                  unique case (req_data.operation)
                     bfgr_pkg::OP_LOAD_WIDTH: begin
                     end
                     bfgr_pkg::OP_LOAD_ATLAS: begin
                        cmd_ff.is_glyph <= 1'b0;
                        state_ff        <= S_PUSH;
                     end
                     bfgr_pkg::OP_SET_POS: begin
                        cur_x_ff  <= req_data.position_x;
                        line_x_ff <= req_data.position_x;
                        cur_y_ff  <= req_data.position_y;
                     end
                     bfgr_pkg::OP_DRAW: begin
                        if (req_data.char_code == bfgr_pkg::CODE_NEWLINE) begin
                           cur_x_ff <= line_x_ff;
                           cur_y_ff <= cur_y_ff + {11'd0, ch};
                        end else if (req_data.char_code == bfgr_pkg::CODE_TAB) begin
                           cur_x_ff <= {tab_sum[15:5], 5'd0};
                        end else begin
                           cmd_ff.is_glyph <= 1'b1;
                           state_ff        <= S_WREAD;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_WREAD: begin
               cmd_ff.width <= wdata_ff;
               cmd_ff.addr  <= '0;
               if (wdata_ff == 5'd0) begin
                  state_ff <= S_IDLE;
               end else if (blank) begin
                  state_ff <= S_PUSH;
               end else begin
                  state_ff <= S_DIV_COLS;
               end
            end
            S_DIV_COLS: begin
               if (div_done) state_ff <= S_DIV_POS;
            end
            S_DIV_POS: begin
               if (div_done) state_ff <= S_MUL_A;
            end
            S_MUL_A: begin
               bx_ff    <= 16'(div_rem * cw);
               by_ff    <= 16'(div_quot * ch);
               state_ff <= S_MUL_B;
            end
            S_MUL_B: begin
               cmd_ff.addr <= 16'(bx_ff + 16'(by_ff * aw));
               state_ff    <= S_PUSH;
            end
            S_PUSH: begin
               if (!q_full) begin
                  if (cmd_ff.is_glyph) cur_x_ff <= cur_x_ff + {11'd0, cmd_ff.width};
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_full = (state_ff != S_IDLE);
   assign q_push   = (state_ff == S_PUSH);
   assign q_data   = cmd_ff;

endmodule
`default_nettype wire

FILE: sv/bfgr_cmdq.sv
`default_nettype none
module bfgr_cmdq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire bfgr_pkg::cmd_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output bfgr_pkg::cmd_type      pop_data,
   output logic                   empty
);

   bfgr_pkg::cmd_type            slot_ff [bfgr_pkg::CMDQ_DEPTH];
   logic [bfgr_pkg::CMDQ_AW-1:0] wr_ff;
   logic [bfgr_pkg::CMDQ_AW-1:0] rd_ff;
   logic [bfgr_pkg::CMDQ_AW:0]   cnt_ff;
   logic                         do_push;
   logic                         do_pop;

   always_comb begin
      full     = (cnt_ff == (bfgr_pkg::CMDQ_AW+1)'(bfgr_pkg::CMDQ_DEPTH));
      empty    = (cnt_ff == '0);
      do_push  = push && !full;
      do_pop   = pop && !empty;
      pop_data = slot_ff[rd_ff];
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_data;
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop) rd_ff <= rd_ff + 1'b1;
         if (do_push && !do_pop) cnt_ff <= cnt_ff + 1'b1;
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

endmodule
`default_nettype wire

FILE: sv/bfgr_back.sv
`default_nettype none
module bfgr_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bfgr_pkg::cfg_type cfg,
   output logic                   q_pop,
   input  wire bfgr_pkg::cmd_type q_data,
   input  wire logic              q_empty,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output bfgr_pkg::rsp_type      rsp_data
);

   typedef enum logic [2:0] {B_IDLE, B_COL, B_DRAIN, B_EMIT} state_type;

   state_type                       state_ff;
   bfgr_pkg::cmd_type               glyph_ff;
   logic [3:0]                      k_ff;
   logic [3:0]                      r_ff;
   logic [bfgr_pkg::ATLAS_ADDR_W-1:0] col_addr_ff;
   logic [bfgr_pkg::ATLAS_ADDR_W-1:0] rd_addr_ff;
   logic [15:0]                     mask_ff;
   logic                            rd_valid_ff;
   logic [3:0]                      rd_row_ff;
   logic                            ink_q_ff;
   logic                            atlas [bfgr_pkg::ATLAS_PIXELS];
   logic                            rsp_valid_ff;
   bfgr_pkg::rsp_type               rsp_ff;

   logic       issue;
   logic       slot_free;
   logic       wr_atlas;
   logic [4:0] ch;
   logic [8:0] aw;

   always_comb begin
      ch        = bfgr_pkg::eff_cell_height(cfg.cell_height);
      aw        = bfgr_pkg::eff_atlas_width(cfg.atlas_width);
      q_pop     = (state_ff == B_IDLE) && !q_empty;
      wr_atlas  = q_pop && !q_data.is_glyph;
      issue     = (state_ff == B_COL) && !glyph_ff.blank;
      slot_free = !rsp_valid_ff || rsp_pop;
   end

   // Atlas ink store
   always_ff @(posedge clock) begin
      if (wr_atlas) atlas[q_data.addr] <= q_data.ink;
      ink_q_ff <= atlas[rd_addr_ff];
   end

   // Walk glyph columns, one atlas read per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= issue;
         rd_row_ff   <= r_ff;
         if (rd_valid_ff && ink_q_ff) mask_ff <= mask_ff | (16'd1 << rd_row_ff);
         if ((state_ff != B_EMIT || !slot_free) && rsp_pop) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            B_IDLE: begin
               if (q_pop && q_data.is_glyph) begin
                  glyph_ff    <= q_data;
                  k_ff        <= 4'd0;
                  r_ff        <= 4'd0;
                  col_addr_ff <= q_data.addr;
                  rd_addr_ff  <= q_data.addr;
                  mask_ff     <= 16'd0;
                  state_ff    <= B_COL;
               end
            end
            B_COL: begin
               if (glyph_ff.blank) begin
                  state_ff <= B_EMIT;
               end else begin
                  r_ff       <= r_ff + 4'd1;
                  rd_addr_ff <= rd_addr_ff + {7'd0, aw};
                  if ({1'b0, r_ff} == ch - 5'd1) state_ff <= B_DRAIN;
               end
            end
            B_DRAIN: begin
               state_ff <= B_EMIT;
            end
            B_EMIT: begin
               if (slot_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_ff.dest_x      <= glyph_ff.x + {12'd0, k_ff};
                  rsp_ff.dest_y      <= glyph_ff.y;
                  rsp_ff.column_mask <= mask_ff;
                  rsp_ff.pixel_color <= cfg.text_color;
                  rsp_ff.last        <= ({1'b0, k_ff} == glyph_ff.width - 5'd1);
                  if ({1'b0, k_ff} == glyph_ff.width - 5'd1) begin
                     state_ff <= B_IDLE;
                  end else begin
                     k_ff        <= k_ff + 4'd1;
                     r_ff        <= 4'd0;
                     col_addr_ff <= col_addr_ff + 1'b1;
                     rd_addr_ff  <= col_addr_ff + 1'b1;
                     mask_ff     <= 16'd0;
                     state_ff    <= B_COL;
                  end
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

FILE: sv/bitmap_font_glyph_renderer.sv
// Channel   Ports                                 Transaction on
// input     req_push, req_full, req_data          req_push & !req_full
// result    rsp_empty, rsp_pop, rsp_data          !rsp_empty & rsp_pop
// config    csr_we, csr_index, csr_wdata          csr_we
//
// Width loads and cursor moves finish in the idle state; atlas loads also pass
// a push state. A non-blank glyph runs two 9-step divides in the front, and the
// back reads each of its columns row by row through the single atlas read port;
// blank glyphs read none. A 4-entry queue parts front and back.
// Reset is synchronous; stores hold garbage until loaded and need no clearing.
// A stalled result holds the back once its output register is full.
`default_nettype none
module bitmap_font_glyph_renderer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire bfgr_pkg::req_type req_data,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output bfgr_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic [2:0]        csr_index,
   input  wire logic [15:0]       csr_wdata
);

   bfgr_pkg::cfg_type cfg_ff;
   bfgr_pkg::cmd_type f_cmd;
   bfgr_pkg::cmd_type q_cmd;
   logic              f_push;
   logic              q_full;
   logic              q_pop;
   logic              q_empty;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_char  <= 8'd32;
         cfg_ff.cell_width  <= 5'd8;
         cfg_ff.cell_height <= 5'd8;
         cfg_ff.atlas_width <= 9'd256;
         cfg_ff.text_color  <= 16'hFFFF;
      end else if (csr_we) begin
         unique case (csr_index)
            bfgr_pkg::CSR_FIRST_CHAR:  cfg_ff.first_char  <= csr_wdata[7:0];
            bfgr_pkg::CSR_CELL_WIDTH:  cfg_ff.cell_width  <= csr_wdata[4:0];
            bfgr_pkg::CSR_CELL_HEIGHT: cfg_ff.cell_height <= csr_wdata[4:0];
            bfgr_pkg::CSR_ATLAS_WIDTH: cfg_ff.atlas_width <= csr_wdata[8:0];
            bfgr_pkg::CSR_TEXT_COLOR:  cfg_ff.text_color  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   bfgr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .q_push   (f_push),
      .q_data   (f_cmd),
      .q_full   (q_full)
   );

   bfgr_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data (f_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_cmd),
      .empty     (q_empty)
   );

   bfgr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_pop     (q_pop),
      .q_data    (q_cmd),
      .q_empty   (q_empty),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

FILE: sv/bfgr_checker.sv
`default_nettype none
module bfgr_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_push,
   input wire logic              req_full,
   input wire bfgr_pkg::req_type req_data,
   input wire logic              rsp_empty,
   input wire logic              rsp_pop,
   input wire bfgr_pkg::rsp_type rsp_data
);

   // No result and an open input right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending after reset");

   a_reset_open: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input blocked after reset");

   // Atlas loads go through the queue, so the front is busy next cycle
   a_atlas_busy: assert property (@(posedge clock) disable iff (reset)
      req_push && !req_full && (req_data.operation == bfgr_pkg::OP_LOAD_ATLAS)
      |=> req_full)
      else $error("atlas load not forwarded");

   // A glyph draw makes the front look up the width table
   a_glyph_busy: assert property (@(posedge clock) disable iff (reset)
      req_push && !req_full && (req_data.operation == bfgr_pkg::OP_DRAW) &&
      (req_data.char_code != bfgr_pkg::CODE_TAB) &&
      (req_data.char_code != bfgr_pkg::CODE_NEWLINE)
      |=> req_full)
      else $error("glyph draw not taken up");

   // A waiting result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("waiting result changed");

endmodule

bind bitmap_font_glyph_renderer bfgr_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .req_data  (req_data),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
`default_nettype wire
